>>> hdl/dsof_pkg.sv
// Shared types and fixed constants for the depth sigma outlier filter.
// No dependencies; used by every dsof module but dsof_div, and by the top level.
package dsof_pkg;

   localparam int DEPTH_W   = 16;
   localparam int MASK_W    = 8;
   localparam int SIGMA_W   = 4;
   localparam int FRAC_BITS = 8;
   localparam int MEAN_W    = 24;
   localparam int LIMIT_W   = 28;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;

   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd3;

   typedef struct packed {
      logic [DEPTH_W-1:0] old_depth;
      logic               frame_end;
      logic               have_prev;
   } item_type;

endpackage

>>> hdl/dsof_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by dsof_stats and dsof_back.
module dsof_div #(
   parameter int NW = 44,
   parameter int DW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int STEP_W = $clog2(NW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NW-1:0]     nreg_ff, nreg_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW:0]       trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, nreg_ff[NW-1]};
      fits    = trial >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      nreg_in = nreg_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NW);
         nreg_in = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? DW'(trial - {1'b0, den}) : DW'(trial);
         nreg_in = {nreg_ff[NW-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      nreg_ff <= nreg_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = nreg_ff;

endmodule

>>> hdl/dsof_front.sv
// Front end: pixel intake, frame store, per-frame sums and frame close handoff.
// Depends on dsof_pkg.
module dsof_front #(
   parameter int MAX_PIXELS = 524288,
   parameter int IDX_W      = 19,
   parameter int CNT_W      = 20,
   parameter int SUM_W      = 36,
   parameter int SQ_W       = 52
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dsof_pkg::DEPTH_W-1:0]  req_depth_sample,
   input  logic [dsof_pkg::MASK_W-1:0]   req_mask_value,
   input  logic                          req_last_pixel,
   input  logic                          q_room,
   input  logic                          q_empty,
   input  logic                          stats_done,
   output logic                          push_valid,
   output dsof_pkg::item_type            push_item,
   output logic                          stats_start,
   output logic [CNT_W-1:0]              stats_cnt,
   output logic [SUM_W-1:0]              stats_sum,
   output logic [SQ_W-1:0]               stats_sq,
   output logic                          commit
);

   logic [dsof_pkg::DEPTH_W-1:0] mem [MAX_PIXELS];
   logic [dsof_pkg::DEPTH_W-1:0] rdata_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_nx;
   logic [SQ_W-1:0]  sq_ff, sq_in, sq_nx;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nx;
   logic             closing_ff, closing_in;
   logic             hv_ff, hv_in;
   logic             s1_valid_ff, s1_end_ff, s1_hv_ff;

   logic                         accept, frame_last, nz;
   logic [dsof_pkg::DEPTH_W-1:0] depth_m;
   logic [2*dsof_pkg::DEPTH_W-1:0] depth_sq;

   assign req_ready  = !closing_ff && q_room;
   assign accept     = req_valid && req_ready;
   assign depth_m    = (req_mask_value == '0) ? '0 : req_depth_sample;
   assign nz         = depth_m != '0;
   assign depth_sq   = depth_m * depth_m;
   assign frame_last = req_last_pixel || (idx_ff == IDX_W'(MAX_PIXELS - 1));
   assign commit     = closing_ff && !s1_valid_ff && q_empty && stats_done;

   always_comb begin
      sum_nx = nz ? sum_ff + SUM_W'(depth_m) : sum_ff;
      sq_nx  = nz ? sq_ff + SQ_W'(depth_sq) : sq_ff;
      cnt_nx = nz ? cnt_ff + 1'b1 : cnt_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      cnt_in     = cnt_ff;
      closing_in = closing_ff;
      hv_in      = hv_ff;
      if (accept) begin
         if (frame_last) begin
            idx_in     = '0;
            sum_in     = '0;
            sq_in      = '0;
            cnt_in     = '0;
            closing_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = sum_nx;
            sq_in  = sq_nx;
            cnt_in = cnt_nx;
         end
      end
      if (commit) begin
         closing_in = 1'b0;
         hv_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff    <= mem[idx_ff];
         mem[idx_ff] <= depth_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         sum_ff      <= '0;
         sq_ff       <= '0;
         cnt_ff      <= '0;
         closing_ff  <= 1'b0;
         hv_ff       <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
         sq_ff       <= sq_in;
         cnt_ff      <= cnt_in;
         closing_ff  <= closing_in;
         hv_ff       <= hv_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_end_ff <= frame_last;
         s1_hv_ff  <= hv_ff;
      end
   end

   assign push_valid          = s1_valid_ff;
   assign push_item.old_depth = rdata_ff;
   assign push_item.frame_end = s1_end_ff;
   assign push_item.have_prev = s1_hv_ff;

   assign stats_start = accept && frame_last;
   assign stats_cnt   = cnt_nx;
   assign stats_sum   = sum_nx;
   assign stats_sq    = sq_nx;

endmodule

>>> hdl/dsof_stats.sv
// Frame close math: serial multiplies, bit-pair square root, mean and sigma divides.
// Depends on dsof_pkg and dsof_div.
module dsof_stats #(
   parameter int CNT_W = 20,
   parameter int SUM_W = 36,
   parameter int SQ_W  = 52
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CNT_W-1:0]              cnt,
   input  logic [SUM_W-1:0]              sum,
   input  logic [SQ_W-1:0]               sq,
   input  logic [dsof_pkg::SIGMA_W-1:0]  sigma_multiple,
   output logic                          busy,
   output logic                          done,
   output logic [dsof_pkg::MEAN_W-1:0]   mean,
   output logic [dsof_pkg::LIMIT_W-1:0]  limit
);

   localparam int F      = dsof_pkg::FRAC_BITS;
   localparam int P_W    = CNT_W + SQ_W;
   localparam int D_W    = P_W + 2 * F;
   localparam int RW     = SUM_W + F;
   localparam int STEP_W = $clog2(RW + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_DIVM = 3'd4;
   localparam logic [2:0] S_DIVS = 3'd5;
   localparam logic [2:0] S_LIM  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic              done_ff, done_in;
   logic              go_ff, go_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [P_W-1:0]    mcand_ff, mcand_in;
   logic [SUM_W-1:0]  mplier_ff, mplier_in;
   logic [P_W-1:0]    acc_ff, acc_in, acc_nx;
   logic [P_W-1:0]    prod_ff, prod_in;
   logic [D_W-1:0]    rad_ff, rad_in;
   logic [RW+1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [dsof_pkg::MEAN_W-1:0]  mean_ff, mean_in;
   logic [dsof_pkg::MEAN_W-1:0]  sigma_ff, sigma_in;
   logic [dsof_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   logic [P_W:0]    diff;
   logic [RW+1:0]   rtry, rtrial;
   logic [RW-1:0]   div_num;
   logic            div_done;
   logic [RW-1:0]   div_quot;

   dsof_div #(.NW(RW), .DW(CNT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .num   (div_num),
      .den   (cnt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_num = (state_ff == S_DIVM) ? {sum_ff, {F{1'b0}}} : root_ff;

   always_comb begin
      acc_nx = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      diff   = {1'b0, prod_ff} - {1'b0, acc_nx};
      rtry   = {rem_ff[RW-1:0], rad_ff[D_W-1:D_W-2]};
      rtrial = {root_ff, 2'b01};

      state_in  = state_ff;
      done_in   = done_ff;
      go_in     = 1'b0;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      mean_in   = mean_ff;
      sigma_in  = sigma_ff;
      limit_in  = limit_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               done_in   = 1'b0;
               cnt_in    = cnt;
               sum_in    = sum;
               mcand_in  = P_W'(sq);
               mplier_in = SUM_W'(cnt);
               acc_in    = '0;
               step_in   = STEP_W'(CNT_W);
               if (cnt == '0) begin
                  mean_in  = '0;
                  limit_in = '0;
                  done_in  = 1'b1;
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            acc_in    = acc_nx;
            mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               prod_in   = acc_nx;
               acc_in    = '0;
               mcand_in  = P_W'(sum_ff);
               mplier_in = sum_ff;
               step_in   = STEP_W'(SUM_W);
               state_in  = S_MUL2;
            end
         end
         S_MUL2: begin
            acc_in    = acc_nx;
            mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               rad_in   = diff[P_W] ? '0 : {diff[P_W-1:0], {(2*F){1'b0}}};
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(RW);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (rtry >= rtrial) begin
               rem_in  = rtry - rtrial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rtry;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            rad_in  = {rad_ff[D_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               go_in    = 1'b1;
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            if (div_done) begin
               mean_in  = div_quot[dsof_pkg::MEAN_W-1:0];
               go_in    = 1'b1;
               state_in = S_DIVS;
            end
         end
         S_DIVS: begin
            if (div_done) begin
               sigma_in = div_quot[dsof_pkg::MEAN_W-1:0];
               state_in = S_LIM;
            end
         end
         S_LIM: begin
            limit_in = dsof_pkg::LIMIT_W'(sigma_ff) * dsof_pkg::LIMIT_W'(sigma_multiple);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b1;
         go_ff    <= 1'b0;
         mean_ff  <= '0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         go_ff    <= go_in;
         mean_ff  <= mean_in;
         limit_ff <= limit_in;
      end
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      sum_ff    <= sum_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      sigma_ff  <= sigma_in;
   end

   assign busy  = state_ff != S_IDLE;
   assign done  = done_ff;
   assign mean  = mean_ff;
   assign limit = limit_ff;

endmodule

>>> hdl/dsof_back.sv
// Back end: item queue, outlier test, kept-pixel mean and result register.
// Depends on dsof_pkg and dsof_div.
module dsof_back #(
   parameter int CNT_W = 20,
   parameter int SUM_W = 36
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  dsof_pkg::item_type            push_item,
   output logic                          q_room,
   output logic                          q_empty,
   input  logic                          commit,
   input  logic [dsof_pkg::MEAN_W-1:0]   stat_mean,
   input  logic [dsof_pkg::LIMIT_W-1:0]  stat_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dsof_pkg::DEPTH_W-1:0]  rsp_filtered_depth,
   output logic                          rsp_pixel_rejected,
   output logic                          rsp_out_valid,
   output logic                          rsp_frame_end,
   output logic [dsof_pkg::MEAN_W-1:0]   rsp_kept_mean
);

   localparam int F  = dsof_pkg::FRAC_BITS;
   localparam int NW = SUM_W + F;

   localparam logic B_IDLE = 1'b0;
   localparam logic B_DIV  = 1'b1;

   dsof_pkg::item_type q_ff [dsof_pkg::QDEPTH];
   logic [dsof_pkg::QPTR_W-1:0] wp_ff, rp_ff;
   logic [dsof_pkg::QCNT_W-1:0] qcnt_ff;

   logic                          state_ff, state_in;
   logic [dsof_pkg::MEAN_W-1:0]   mean_ff;
   logic [dsof_pkg::LIMIT_W-1:0]  limit_ff;
   logic [SUM_W-1:0]              ks_ff, ks_in, ks_nx;
   logic [CNT_W-1:0]              kc_ff, kc_in, kc_nx;
   logic                          go_ff, go_in;
   logic [NW-1:0]                 div_num_ff;
   logic [CNT_W-1:0]              div_den_ff;
   logic                          div_done;
   logic [NW-1:0]                 div_quot;

   logic                          rv_ff, rv_in;
   logic [dsof_pkg::DEPTH_W-1:0]  filt_ff, filt_in;
   logic                          rej_ff, rej_in, ov_ff, ov_in, fe_ff, fe_in;
   logic [dsof_pkg::MEAN_W-1:0]   km_ff, km_in;

   dsof_pkg::item_type            head;
   logic                          slot_free, pop, nz, rej, keep;
   logic [dsof_pkg::MEAN_W-1:0]   pval, diff;

   dsof_div #(.NW(NW), .DW(CNT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign head      = q_ff[rp_ff];
   assign q_empty   = qcnt_ff == '0;
   assign q_room    = qcnt_ff <= dsof_pkg::QCNT_W'(dsof_pkg::QDEPTH - 2);
   assign slot_free = !rv_ff || rsp_ready;
   assign pop       = (state_ff == B_IDLE) && !q_empty && slot_free;

   always_comb begin
      nz    = head.old_depth != '0;
      pval  = {head.old_depth, {F{1'b0}}};
      diff  = (pval >= mean_ff) ? pval - mean_ff : mean_ff - pval;
      rej   = head.have_prev && nz &&
              ({{(dsof_pkg::LIMIT_W - dsof_pkg::MEAN_W){1'b0}}, diff} > limit_ff);
      keep  = head.have_prev && nz && !rej;
      ks_nx = keep ? ks_ff + SUM_W'(head.old_depth) : ks_ff;
      kc_nx = keep ? kc_ff + 1'b1 : kc_ff;

      state_in = state_ff;
      ks_in    = ks_ff;
      kc_in    = kc_ff;
      go_in    = 1'b0;
      rv_in    = rv_ff && !rsp_ready;
      filt_in  = filt_ff;
      rej_in   = rej_ff;
      ov_in    = ov_ff;
      fe_in    = fe_ff;
      km_in    = km_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               filt_in = keep ? head.old_depth : '0;
               rej_in  = rej;
               ov_in   = head.have_prev;
               fe_in   = head.have_prev && head.frame_end;
               km_in   = '0;
               if (head.frame_end) begin
                  ks_in = '0;
                  kc_in = '0;
               end else begin
                  ks_in = ks_nx;
                  kc_in = kc_nx;
               end
               if (head.have_prev && head.frame_end && kc_nx != '0) begin
                  go_in    = 1'b1;
                  state_in = B_DIV;
               end else begin
                  rv_in = 1'b1;
               end
            end
         end
         B_DIV: begin
            if (div_done) begin
               km_in    = div_quot[dsof_pkg::MEAN_W-1:0];
               rv_in    = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         qcnt_ff  <= '0;
         state_ff <= B_IDLE;
         mean_ff  <= '0;
         limit_ff <= '0;
         ks_ff    <= '0;
         kc_ff    <= '0;
         go_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (push_valid) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         qcnt_ff  <= qcnt_ff + dsof_pkg::QCNT_W'(push_valid) - dsof_pkg::QCNT_W'(pop);
         if (commit) begin
            mean_ff  <= stat_mean;
            limit_ff <= stat_limit;
         end
         state_ff <= state_in;
         ks_ff    <= ks_in;
         kc_ff    <= kc_in;
         go_ff    <= go_in;
         rv_ff    <= rv_in;
      end
      if (push_valid) begin
         q_ff[wp_ff] <= push_item;
      end
      if (go_in) begin
         div_num_ff <= {ks_nx, {F{1'b0}}};
         div_den_ff <= kc_nx;
      end
      filt_ff <= filt_in;
      rej_ff  <= rej_in;
      ov_ff   <= ov_in;
      fe_ff   <= fe_in;
      km_ff   <= km_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_filtered_depth = filt_ff;
   assign rsp_pixel_rejected = rej_ff;
   assign rsp_out_valid      = ov_ff;
   assign rsp_frame_end      = fe_ff;
   assign rsp_kept_mean      = km_ff;

endmodule

>>> hdl/depth_frame_sigma_outlier_filter_unit.sv
// Top level of the depth sigma outlier filter: front, frame statistics, back, CSR.
// Depends on dsof_pkg, dsof_front, dsof_stats, dsof_back (dsof_div below them).
//
//   port group   dir   transfer when          carries
//   req_*        in    req_valid & req_ready  depth sample, mask byte, last pixel flag
//   rsp_*        out   rsp_valid & rsp_ready  filtered depth, reject, valid, frame end, mean
//   csr_*        in    csr_wr_en              sigma multiple, 4 bits
//
// One pixel per cycle inside a frame while the queue has room; the frame store is read
// and written once per pixel. After a frame's last pixel req_ready drops until the close
// math (serial multiplier, square root and divider) finishes and the queue has drained.
// A frame end with kept pixels holds the result path for the kept mean divide.
// Reset clears control only; the frame store is not cleared. A 4-entry queue lets the
// two sides stall independently.
module depth_frame_sigma_outlier_filter_unit #(
   parameter int MAX_PIXELS = 524288
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dsof_pkg::DEPTH_W-1:0]  req_depth_sample,
   input  logic [dsof_pkg::MASK_W-1:0]   req_mask_value,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dsof_pkg::DEPTH_W-1:0]  rsp_filtered_depth,
   output logic                          rsp_pixel_rejected,
   output logic                          rsp_out_valid,
   output logic                          rsp_frame_end,
   output logic [dsof_pkg::MEAN_W-1:0]   rsp_kept_mean,
   input  logic                          csr_wr_en,
   input  logic [dsof_pkg::SIGMA_W-1:0]  csr_wr_data
);

   localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = dsof_pkg::DEPTH_W + CNT_W;
   localparam int SQ_W  = 2 * dsof_pkg::DEPTH_W + CNT_W;

   logic [dsof_pkg::SIGMA_W-1:0] sigma_ff;

   logic                          q_room, q_empty, push_valid, commit;
   dsof_pkg::item_type            push_item;
   logic                          stats_start, stats_busy, stats_done;
   logic [CNT_W-1:0]              stats_cnt;
   logic [SUM_W-1:0]              stats_sum;
   logic [SQ_W-1:0]               stats_sq;
   logic [dsof_pkg::MEAN_W-1:0]   stat_mean;
   logic [dsof_pkg::LIMIT_W-1:0]  stat_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= dsof_pkg::SIGMA_RESET;
      end else if (csr_wr_en) begin
         sigma_ff <= csr_wr_data;
      end
   end

   dsof_front #(
      .MAX_PIXELS (MAX_PIXELS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .SQ_W       (SQ_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_depth_sample (req_depth_sample),
      .req_mask_value   (req_mask_value),
      .req_last_pixel   (req_last_pixel),
      .q_room           (q_room),
      .q_empty          (q_empty),
      .stats_done       (stats_done),
      .push_valid       (push_valid),
      .push_item        (push_item),
      .stats_start      (stats_start),
      .stats_cnt        (stats_cnt),
      .stats_sum        (stats_sum),
      .stats_sq         (stats_sq),
      .commit           (commit)
   );

   dsof_stats #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SQ_W  (SQ_W)
   ) u_stats (
      .clock          (clock),
      .reset          (reset),
      .start          (stats_start),
      .cnt            (stats_cnt),
      .sum            (stats_sum),
      .sq             (stats_sq),
      .sigma_multiple (sigma_ff),
      .busy           (stats_busy),
      .done           (stats_done),
      .mean           (stat_mean),
      .limit          (stat_limit)
   );

   dsof_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .q_room             (q_room),
      .q_empty            (q_empty),
      .commit             (commit),
      .stat_mean          (stat_mean),
      .stat_limit         (stat_limit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_depth (rsp_filtered_depth),
      .rsp_pixel_rejected (rsp_pixel_rejected),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_kept_mean      (rsp_kept_mean)
   );

   a_no_intake_while_closing: assert property (@(posedge clock) disable iff (reset)
      stats_busy |-> !req_ready)
      else $error("pixel intake open while frame statistics are being computed");

   a_commit_after_stats: assert property (@(posedge clock) disable iff (reset)
      commit |-> (stats_done && q_empty && !stats_busy))
      else $error("frame statistics committed before they were ready");

   a_frame_end_is_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_out_valid)
      else $error("frame end flagged on a result without a previous frame");

endmodule

>>> test/dsof_checker.sv
// Checker for the depth sigma outlier filter: watches the req, rsp and csr ports,
// predicts each rsp transfer from the accepted pixels and compares field by field.
// Depends on dsof_pkg for field widths and the sigma multiple reset value.
module dsof_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [dsof_pkg::DEPTH_W-1:0] req_depth_sample,
   input  logic [dsof_pkg::MASK_W-1:0]  req_mask_value,
   input  logic                         req_last_pixel,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [dsof_pkg::DEPTH_W-1:0] rsp_filtered_depth,
   input  logic                         rsp_pixel_rejected,
   input  logic                         rsp_out_valid,
   input  logic                         rsp_frame_end,
   input  logic [dsof_pkg::MEAN_W-1:0]  rsp_kept_mean,
   input  logic                         csr_wr_en,
   input  logic [dsof_pkg::SIGMA_W-1:0] csr_wr_data,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX = 524288;
   localparam logic [63:0] MEAN_SAT = 64'hFF_FFFF;
   localparam logic [63:0] LIMIT_SAT = 64'hFFF_FFFF;

   typedef struct packed {
      logic [dsof_pkg::DEPTH_W-1:0] depth;
      logic                         rejected;
      logic                         valid;
      logic                         frame_end;
      logic [dsof_pkg::MEAN_W-1:0]  kept_mean;
   } pixel_out_type;

   pixel_out_type                filtered_q[$];
   logic [dsof_pkg::DEPTH_W-1:0] last_frame[int];
   logic [19:0]                  pix_idx;
   logic [35:0]                  depth_sum;
   logic [51:0]                  depth_sq_sum;
   logic [19:0]                  depth_cnt;
   logic [23:0]                  frame_mean;
   logic [27:0]                  frame_limit;
   logic [35:0]                  kept_sum;
   logic [19:0]                  kept_cnt;
   logic                         have_frame;
   logic [dsof_pkg::SIGMA_W-1:0] sigma_mult;

   function automatic logic [63:0] isqrt(input logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] cc;
      r = '0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (64'd1 << b);
         cc = {64'd0, c} * {64'd0, c};
         if (cc <= x) r = c;
      end
      return r;
   endfunction

   task automatic close_stats();
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] dd;
      logic [63:0]  mn;
      logic [63:0]  sg;
      logic [63:0]  lm;
      mn = '0;
      lm = '0;
      if (depth_cnt != 0) begin
         a = 128'(depth_cnt) * 128'(depth_sq_sum);
         b = 128'(depth_sum) * 128'(depth_sum);
         mn = (64'(depth_sum) << dsof_pkg::FRAC_BITS) / 64'(depth_cnt);
         if (mn > MEAN_SAT) mn = MEAN_SAT;
         dd = (b <= a) ? a - b : '0;
         dd = dd << (2 * dsof_pkg::FRAC_BITS);
         sg = isqrt(dd) / 64'(depth_cnt);
         if (sg > LIMIT_SAT) sg = LIMIT_SAT;
         lm = sg * 64'(sigma_mult);
         if (lm > LIMIT_SAT) lm = LIMIT_SAT;
      end
      frame_mean = mn[23:0];
      frame_limit = lm[27:0];
      depth_sum = '0;
      depth_sq_sum = '0;
      depth_cnt = '0;
      have_frame = 1'b1;
      pix_idx = '0;
   endtask

   task automatic predict_pixel(input logic [dsof_pkg::DEPTH_W-1:0] din,
                                input logic [dsof_pkg::MASK_W-1:0] m,
                                input logic l);
      logic [dsof_pkg::DEPTH_W-1:0] d;
      logic [dsof_pkg::DEPTH_W-1:0] old;
      logic [19:0]                  i;
      logic                         at_end;
      logic [31:0]                  p;
      logic [31:0]                  diff;
      logic [63:0]                  km;
      pixel_out_type                e;
      d = (m == 0) ? '0 : din;
      i = (pix_idx >= FRAME_MAX) ? '0 : pix_idx;
      at_end = l || (i == FRAME_MAX - 1);
      old = last_frame.exists(int'(i)) ? last_frame[int'(i)] : '0;
      last_frame[int'(i)] = d;
      e = '0;
      if (have_frame) begin
         e.valid = 1'b1;
         if (old != 0) begin
            p = 32'(old) << dsof_pkg::FRAC_BITS;
            diff = (p >= 32'(frame_mean)) ? p - 32'(frame_mean) : 32'(frame_mean) - p;
            if (diff > 32'(frame_limit)) begin
               e.rejected = 1'b1;
            end else begin
               e.depth = old;
               kept_sum += 36'(old);
               kept_cnt++;
            end
         end
         if (at_end) begin
            e.frame_end = 1'b1;
            if (kept_cnt != 0) begin
               km = (64'(kept_sum) << dsof_pkg::FRAC_BITS) / 64'(kept_cnt);
               if (km > MEAN_SAT) km = MEAN_SAT;
               e.kept_mean = km[23:0];
            end
         end
      end
      if (d != 0) begin
         depth_sum += 36'(d);
         depth_sq_sum += 52'(32'(d) * 32'(d));
         depth_cnt++;
      end
      if (at_end) begin
         kept_sum = '0;
         kept_cnt = '0;
         close_stats();
      end else begin
         pix_idx = i + 1;
      end
      filtered_q.push_back(e);
   endtask

   task automatic report(input string what);
      $display("%0t: rsp mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic check_result();
      pixel_out_type e;
      if (filtered_q.size() == 0) begin
         report("transfer with nothing pending");
         return;
      end
      e = filtered_q.pop_front();
      if (rsp_filtered_depth !== e.depth)
         report($sformatf("filtered_depth %0d, want %0d", rsp_filtered_depth, e.depth));
      if (rsp_pixel_rejected !== e.rejected)
         report($sformatf("pixel_rejected %0b, want %0b", rsp_pixel_rejected, e.rejected));
      if (rsp_out_valid !== e.valid)
         report($sformatf("out_valid %0b, want %0b", rsp_out_valid, e.valid));
      if (rsp_frame_end !== e.frame_end)
         report($sformatf("frame_end %0b, want %0b", rsp_frame_end, e.frame_end));
      if (rsp_kept_mean !== e.kept_mean)
         report($sformatf("kept_mean %0d, want %0d", rsp_kept_mean, e.kept_mean));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         filtered_q.delete();
         last_frame.delete();
         pix_idx = '0;
         depth_sum = '0;
         depth_sq_sum = '0;
         depth_cnt = '0;
         frame_mean = '0;
         frame_limit = '0;
         kept_sum = '0;
         kept_cnt = '0;
         have_frame = 1'b0;
         sigma_mult = dsof_pkg::SIGMA_RESET;
         fail_count = 0;
      end else begin
         if (csr_wr_en) sigma_mult = csr_wr_data;
         if (req_valid && req_ready)
            predict_pixel(req_depth_sample, req_mask_value, req_last_pixel);
         if (rsp_valid && rsp_ready) check_result();
      end
      outstanding = filtered_q.size();
   end

endmodule

>>> test/tb.sv
// Testbench top for depth_frame_sigma_outlier_filter_unit: clock, reset, pixel frames,
// csr writes and rsp back-pressure; dsof_checker predicts and compares the results.
// Depends on dsof_pkg, the unit and dsof_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int FRAME_LEN = 16;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [dsof_pkg::DEPTH_W-1:0] req_depth_sample = '0;
   logic [dsof_pkg::MASK_W-1:0]  req_mask_value = '0;
   logic                         req_last_pixel = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [dsof_pkg::DEPTH_W-1:0] rsp_filtered_depth;
   logic                         rsp_pixel_rejected;
   logic                         rsp_out_valid;
   logic                         rsp_frame_end;
   logic [dsof_pkg::MEAN_W-1:0]  rsp_kept_mean;
   logic                         csr_wr_en = 1'b0;
   logic [dsof_pkg::SIGMA_W-1:0] csr_wr_data = '0;

   int fail_count;
   int outstanding;
   int send_idle = 0;
   int recv_idle = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   depth_frame_sigma_outlier_filter_unit dut (.*);

   dsof_checker chk (.*);

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [dsof_pkg::DEPTH_W-1:0] d,
                             input logic [dsof_pkg::MASK_W-1:0] m,
                             input logic l);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_depth_sample <= d;
      req_mask_value <= m;
      req_last_pixel <= l;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_sigma(input logic [dsof_pkg::SIGMA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [dsof_pkg::DEPTH_W-1:0] near(input int center, input int spread);
      int v;
      v = center + $urandom_range(2 * spread) - spread;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
      return dsof_pkg::DEPTH_W'(v);
   endfunction

   // frames never exceed the first one, so every store read was written before
   task automatic random_frame(output int len);
      int center;
      int spread;
      int r;
      logic [dsof_pkg::DEPTH_W-1:0] d;
      logic [dsof_pkg::MASK_W-1:0]  m;
      len = $urandom_range(1, FRAME_LEN);
      center = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200, 5000);
      spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1500);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(99);
         if (r < 6) d = '0;
         else if (r < 16) d = dsof_pkg::DEPTH_W'($urandom());
         else d = near(center, spread);
         r = $urandom_range(99);
         if (r < 8) m = '0;
         else if (r < 30) m = dsof_pkg::MASK_W'($urandom());
         else m = dsof_pkg::MASK_W'($urandom_range(1, 255));
         send_pixel(d, m, i == len - 1);
      end
   endtask

   initial begin
      logic [dsof_pkg::SIGMA_W-1:0] sigma_plan[6];
      int sent;
      int len;
      sigma_plan = '{4'd15, 4'd1, 4'd0, 4'd7, 4'd3, 4'd9};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // longest frame first: extremes, zero mask, zero depth, a far outlier
      send_pixel(16'd1000, 8'd255, 1'b0);
      send_pixel(16'd1010, 8'd1, 1'b0);
      send_pixel(16'd65535, 8'd128, 1'b0);
      send_pixel(16'd990, 8'd0, 1'b0);
      send_pixel(16'd0, 8'd255, 1'b0);
      send_pixel(16'd1, 8'd77, 1'b0);
      for (int i = 6; i < FRAME_LEN; i++)
         send_pixel(16'd995 + 16'(i), 8'(i * 13 + 1), i == FRAME_LEN - 1);
      send_pixel(16'd65535, 8'd255, 1'b0);
      send_pixel(16'd0, 8'd0, 1'b0);
      send_pixel(16'd500, 8'd255, 1'b1);
      send_pixel(16'd65535, 8'd255, 1'b1);
      send_pixel(16'd1234, 8'd0, 1'b0);
      send_pixel(16'hAAAA, 8'd0, 1'b0);
      send_pixel(16'h5555, 8'd0, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_sigma(ph == 5 ? dsof_pkg::SIGMA_W'($urandom()) : sigma_plan[ph]);
         send_idle = (ph < 2) ? 6 : (ph < 4) ? 87 : 0;
         recv_idle = (ph < 2) ? 87 : (ph < 4) ? 6 : 0;
         sent = 0;
         while (sent < 320) begin
            random_frame(len);
            sent += len;
            if ($urandom_range(19) == 0) drain();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
hdl/dsof_pkg.sv
hdl/dsof_div.sv
hdl/dsof_front.sv
hdl/dsof_stats.sv
hdl/dsof_back.sv
hdl/depth_frame_sigma_outlier_filter_unit.sv
test/dsof_checker.sv
test/tb.sv
